@@ rtl/wva_pkg.sv @@
// shared types, constants and label table for the weighted vote arbiter
`timescale 1ns / 1ps

package wva_pkg;

    localparam int VOTERS_MAX      = 12;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int SLOT_W          = 16;
    localparam int TREE_LEAVES     = 16;
    localparam int MASK_W          = 12;
    localparam int IN_DATA_W       = 16;
    localparam int LABEL_W         = 5;
    localparam int OUTCOME_W       = 2;
    localparam int CNT_W           = 4;
    localparam int TOTAL_W         = 32;
    localparam int OUT_FIELDS_W    = LABEL_W + OUTCOME_W + CNT_W + 3 * TOTAL_W;
    localparam int OUT_DATA_W      = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_ADDR_W      = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int LFSR_W          = 16;
    localparam int MOD_STEPS       = 8;
    localparam int MOD_CNT_W       = 3;

    localparam logic [LFSR_W-1:0] SEED_RESET = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_MASK  = 16'hB400;

    localparam logic [CFG_ADDR_W-1:0] REG_WEIGHTS_A = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WEIGHTS_B = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WEIGHTS_C = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RNG_SEED  = 2'd3;

    localparam logic [OUTCOME_W-1:0] OUTCOME_UNKNOWN   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_CONFIRMED = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_CONFUSED  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCORE,
        ST_MAX,
        ST_TIE,
        ST_MOD,
        ST_OUT
    } state_t;

    function automatic logic [LABEL_W-1:0] label_of(input int idx);
        logic [LABEL_W-1:0] lbl;
        case (idx)
            0:       lbl = 5'd1;
            1:       lbl = 5'd2;
            2:       lbl = 5'd3;
            3:       lbl = 5'd4;
            4:       lbl = 5'd5;
            5:       lbl = 5'd6;
            6:       lbl = 5'd7;
            7:       lbl = 5'd12;
            8:       lbl = 5'd13;
            9:       lbl = 5'd16;
            10:      lbl = 5'd17;
            11:      lbl = 5'd24;
            default: lbl = 5'd0;
        endcase
        return lbl;
    endfunction

endpackage

@@ rtl/weighted_vote_arbiter.sv @@
// top level of the weighted vote arbiter: control, lanes, merge, counters
`timescale 1ns / 1ps

// Each accepted item is a 12-bit vote mask; the block returns one item with the label of
// the yes-voter holding the highest positive weight, the outcome, the tie count and the
// three saturating outcome totals. When a tie has to be broken, the item also passes
// through the two-bits-per-cycle remainder unit that reduces the tie-break lfsr modulo
// the tie count. The next item can be taken in the cycle after the result is loaded.
// Scores are taken by one lane per voter and reduced in a registered compare tree. A new
// item is taken while a finished result still waits on the output. Weights and seed
// must be written through the cfg port only while the block is idle; the block itself
// does not enforce this. A zero seed loads the reset seed instead.

module weighted_vote_arbiter
    import wva_pkg::*;
#(
    parameter int NUM_VOTERS  = VOTERS_MAX,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // vote_mask[11:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // winner_label[4:0], outcome[6:5], tie_count[10:7], confirmed_total[42:11],
    // confused_total[74:43], unknown_total[106:75]
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SW = WEIGHT_BITS - 1;

    state_t state_reg;
    state_t state_next;

    logic [CFG_DATA_W-1:0] weights_a_reg;
    logic [CFG_DATA_W-1:0] weights_b_reg;
    logic [CFG_DATA_W-1:0] weights_c_reg;
    logic [LFSR_W-1:0]     lfsr_reg;
    logic [LFSR_W-1:0]     lfsr_adv;

    logic [MASK_W-1:0]     mask_reg;
    logic [NUM_VOTERS-1:0] tie_vec_reg;
    logic [NUM_VOTERS-1:0] tie_now;
    logic [CNT_W-1:0]      tie_cnt_reg;
    logic [CNT_W-1:0]      tie_cnt_now;
    logic [CNT_W-1:0]      pick_reg;

    logic [NUM_VOTERS*SW-1:0]  scores;
    logic [SW-1:0]             best;
    logic [LABEL_W-1:0]        lane_label [NUM_VOTERS];
    logic [LABEL_W-1:0]        label_sel;

    logic                  mod_done;
    logic [CNT_W-1:0]      mod_rem;

    logic [TOTAL_W-1:0]    confirmed_reg;
    logic [TOTAL_W-1:0]    confused_reg;
    logic [TOTAL_W-1:0]    unknown_reg;
    logic [TOTAL_W-1:0]    confirmed_next;
    logic [TOTAL_W-1:0]    confused_next;
    logic [TOTAL_W-1:0]    unknown_next;
    logic [OUTCOME_W-1:0]  outcome_now;

    logic                  out_valid_reg;
    logic [LABEL_W-1:0]    out_label_reg;
    logic [OUTCOME_W-1:0]  out_outcome_reg;
    logic [CNT_W-1:0]      out_ties_reg;

    logic in_fire;
    logic capture_score;
    logic capture_best;
    logic tie_step;
    logic mod_start;
    logic out_load;

    assign in_fire = s_tvalid && s_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SCORE;
                end
            end
            ST_SCORE: state_next = ST_MAX;
            ST_MAX:   state_next = ST_TIE;
            ST_TIE:
            begin
                if (tie_cnt_now > CNT_W'(1))
                begin
                    state_next = ST_MOD;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready      = 1'b0;
        capture_score = 1'b0;
        capture_best  = 1'b0;
        tie_step      = 1'b0;
        mod_start     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready      = 1'b1;
            ST_SCORE: capture_score = 1'b1;
            ST_MAX:   capture_best  = 1'b1;
            ST_TIE:
            begin
                tie_step  = 1'b1;
                mod_start = (tie_cnt_now > CNT_W'(1));
            end
            ST_MOD:   out_load = 1'b0;
            ST_OUT:   out_load = !out_valid_reg || m_tready;
            default:  s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers and tie-break lfsr
    assign lfsr_adv = lfsr_reg[0] ? ({1'b0, lfsr_reg[LFSR_W-1:1]} ^ LFSR_MASK)
                                  : {1'b0, lfsr_reg[LFSR_W-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_a_reg <= '0;
            weights_b_reg <= '0;
            weights_c_reg <= '0;
            lfsr_reg      <= SEED_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_WEIGHTS_A: weights_a_reg <= cfg_data;
                REG_WEIGHTS_B: weights_b_reg <= cfg_data;
                REG_WEIGHTS_C: weights_c_reg <= cfg_data;
                REG_RNG_SEED:
                begin
                    lfsr_reg <= (cfg_data[LFSR_W-1:0] == '0) ? SEED_RESET
                                                             : cfg_data[LFSR_W-1:0];
                end
                default: lfsr_reg <= lfsr_reg;
            endcase
        end
        else if (mod_start)
        begin
            lfsr_reg <= lfsr_adv;
        end
    end

    // lanes
    for (genvar v = 0; v < NUM_VOTERS; v++)
    begin : g_lane
        logic [SLOT_W-1:0] slot;
        if (v < 4)
        begin : g_a
            assign slot = weights_a_reg[SLOT_W*(v%4) +: SLOT_W];
        end
        else if (v < 8)
        begin : g_b
            assign slot = weights_b_reg[SLOT_W*(v%4) +: SLOT_W];
        end
        else
        begin : g_c
            assign slot = weights_c_reg[SLOT_W*(v%4) +: SLOT_W];
        end

        wva_lane #(
            .IDX         (v),
            .NUM_VOTERS  (NUM_VOTERS),
            .WEIGHT_BITS (WEIGHT_BITS)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .capture (capture_score),
            .vote    (mask_reg[v]),
            .slot    (slot),
            .best    (best),
            .tie_vec (tie_vec_reg),
            .pick    (pick_reg),
            .score   (scores[v*SW +: SW]),
            .tie     (tie_now[v]),
            .label   (lane_label[v])
        );
    end

    wva_merge #(
        .NUM_VOTERS  (NUM_VOTERS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .capture (capture_best),
        .scores  (scores),
        .best    (best)
    );

    wva_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (lfsr_adv),
        .divisor   (tie_cnt_now),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign tie_cnt_now = CNT_W'($countones(tie_now));

    always_comb
    begin
        label_sel = '0;
        for (int v = 0; v < NUM_VOTERS; v++)
        begin
            label_sel = label_sel | lane_label[v];
        end
    end

    // item datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mask_reg <= s_tdata[MASK_W-1:0];
        end
        if (tie_step)
        begin
            tie_vec_reg <= tie_now;
            tie_cnt_reg <= tie_cnt_now;
            pick_reg    <= '0;
        end
        else if (mod_done)
        begin
            pick_reg <= mod_rem;
        end
    end

    // outcome and saturating totals
    always_comb
    begin
        confirmed_next = confirmed_reg;
        confused_next  = confused_reg;
        unknown_next   = unknown_reg;
        if (tie_cnt_reg == '0)
        begin
            outcome_now = OUTCOME_UNKNOWN;
            if (unknown_reg != '1)
            begin
                unknown_next = unknown_reg + 1'b1;
            end
        end
        else if (tie_cnt_reg == CNT_W'(1))
        begin
            outcome_now = OUTCOME_CONFIRMED;
            if (confirmed_reg != '1)
            begin
                confirmed_next = confirmed_reg + 1'b1;
            end
        end
        else
        begin
            outcome_now = OUTCOME_CONFUSED;
            if (confused_reg != '1)
            begin
                confused_next = confused_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirmed_reg <= '0;
            confused_reg  <= '0;
            unknown_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                confirmed_reg <= confirmed_next;
                confused_reg  <= confused_next;
                unknown_reg   <= unknown_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_label_reg   <= label_sel;
            out_outcome_reg <= outcome_now;
            out_ties_reg    <= tie_cnt_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, unknown_reg, confused_reg,
                       confirmed_reg, out_ties_reg, out_outcome_reg, out_label_reg};

endmodule

@@ rtl/wva_lane.sv @@
// one voter lane: qualified score, tie flag and rank match for the pick
`timescale 1ns / 1ps

module wva_lane
    import wva_pkg::*;
#(
    parameter int IDX         = 0,
    parameter int NUM_VOTERS  = VOTERS_MAX,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   capture,
    input  logic                   vote,
    input  logic [SLOT_W-1:0]      slot,
    input  logic [WEIGHT_BITS-2:0] best,
    input  logic [NUM_VOTERS-1:0]  tie_vec,
    input  logic [CNT_W-1:0]       pick,
    output logic [WEIGHT_BITS-2:0] score,
    output logic                   tie,
    output logic [LABEL_W-1:0]     label
);

    localparam logic [NUM_VOTERS-1:0] LOW_MASK = NUM_VOTERS'((64'd1 << IDX) - 64'd1);

    logic [WEIGHT_BITS-1:0] weight;
    logic                   positive;
    logic [WEIGHT_BITS-2:0] score_reg;
    logic [WEIGHT_BITS-2:0] score_next;
    logic [CNT_W-1:0]       rank;
    logic                   hit;

    assign weight     = slot[WEIGHT_BITS-1:0];
    assign positive   = !weight[WEIGHT_BITS-1] && (|weight[WEIGHT_BITS-2:0]);
    assign score_next = (vote && positive) ? weight[WEIGHT_BITS-2:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_reg <= '0;
        end
        else if (capture)
        begin
            score_reg <= score_next;
        end
    end

    assign score = score_reg;
    assign tie   = (best != '0) && (score_reg == best);
    assign rank  = CNT_W'($countones(tie_vec & LOW_MASK));
    assign hit   = tie_vec[IDX] && (rank == pick);
    assign label = hit ? label_of(IDX) : '0;

endmodule

@@ rtl/wva_merge.sv @@
// maximum of the lane scores over a binary compare tree, registered
`timescale 1ns / 1ps

module wva_merge
    import wva_pkg::*;
#(
    parameter int NUM_VOTERS  = VOTERS_MAX,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 capture,
    input  logic [NUM_VOTERS*(WEIGHT_BITS-1)-1:0] scores,
    output logic [WEIGHT_BITS-2:0]               best
);

    localparam int SW = WEIGHT_BITS - 1;

    logic [SW-1:0] node [2*TREE_LEAVES];
    logic [SW-1:0] best_reg;

    always_comb
    begin
        for (int i = 0; i < TREE_LEAVES; i++)
        begin
            node[i] = '0;
            if (i < NUM_VOTERS)
            begin
                node[TREE_LEAVES + i] = scores[i*SW +: SW];
            end
            else
            begin
                node[TREE_LEAVES + i] = '0;
            end
        end
        for (int i = TREE_LEAVES - 1; i >= 1; i--)
        begin
            node[i] = (node[2*i] >= node[2*i+1]) ? node[2*i] : node[2*i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else if (capture)
        begin
            best_reg <= node[1];
        end
    end

    assign best = best_reg;

endmodule

@@ rtl/wva_mod.sv @@
// lfsr value modulo tie count, restoring remainder two bits per cycle
`timescale 1ns / 1ps

module wva_mod
    import wva_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [LFSR_W-1:0] dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [CNT_W-1:0]  remainder
);

    logic [LFSR_W-1:0]    dvd_reg;
    logic [LFSR_W-1:0]    dvd_next;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     rem_next;
    logic [CNT_W-1:0]     div_reg;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    always_comb
    begin
        logic [CNT_W:0] r;
        logic [CNT_W-1:0] acc;
        acc = rem_reg;
        for (int k = 0; k < 2; k++)
        begin
            r = {acc, dvd_reg[LFSR_W-1-k]};
            if (r >= {1'b0, div_reg})
            begin
                r = r - {1'b0, div_reg};
            end
            acc = r[CNT_W-1:0];
        end
        rem_next = acc;
        dvd_next = {dvd_reg[LFSR_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= MOD_CNT_W'(MOD_STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                done_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
